@@ hdl/ray_plane_hit_checker_assert.svh @@
// Assertion macros shared by the ray against plane hit checker.
`ifndef RAY_PLANE_HIT_CHECKER_ASSERT_SVH
`define RAY_PLANE_HIT_CHECKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RPH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ray plane hit checker: check failed");

// Next-cycle implication, checked out of reset.
`define RPH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ray plane hit checker: check failed");

`endif

@@ hdl/rph_pkg.sv @@
// Package: constants and register codes of the ray against plane hit checker.
package rph_pkg;

  localparam int SQUARE_SIZE_DEF = 100;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_W         = 32;
  localparam int T_W             = 31;
  localparam int COLOR_W         = 2;
  localparam int CFG_IDX_W       = 3;

  localparam logic [T_W-1:0] T_MAX = '1;

  localparam logic [COLOR_W-1:0] COLOR_BASE  = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd2;

  localparam int MODE_CHESS = 0;
  localparam int MODE_LIMIT = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X  = 3'd0,
    REG_CENTRE_Y  = 3'd1,
    REG_CENTRE_Z  = 3'd2,
    REG_NORMAL_X  = 3'd3,
    REG_NORMAL_Y  = 3'd4,
    REG_NORMAL_Z  = 3'd5,
    REG_MODE_BITS = 3'd6,
    REG_SQ_COUNT  = 3'd7
  } rph_reg_t;

endpackage

@@ hdl/rph_if.sv @@
// Interfaces: ray input, hit result and configuration write channels.
interface rph_ray_if;
  import rph_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] start_z;
  logic [COORD_W-1:0] dir_x;
  logic [COORD_W-1:0] dir_y;
  logic [COORD_W-1:0] dir_z;
  modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rph_res_if;
  import rph_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [T_W-1:0]     distance_t;
  logic [COLOR_W-1:0] color_code;
  modport source (output valid, hit, distance_t, color_code, input ready);
  modport sink (input valid, hit, distance_t, color_code, output ready);
endinterface

interface rph_cfg_if;
  import rph_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/ray_plane_hit_checker.sv @@
// Top level: pipelined ray against plane intersection with chess colouring.
//
// in_ch carries one ray per beat (start and direction, signed fixed point),
// out_ch one result per ray (hit, distance_t, color_code), in ray order.
// cfg_ch writes the plane registers by index and is always ready; the user must
// write it only while no ray is in flight, which the block does not enforce.
// All eight index values name a register. Throughput: one ray per cycle while
// out_ch.ready stays high. Most of the pipeline is the restoring divider (one
// quotient bit per stage, 31 stages) and the cell parity reduction (8 bits of
// the hit cell coordinate per stage).
// Every stage has a valid bit; a stage takes new data when it is empty or the
// stage after it moves, so bubbles close up and in_ch stays ready while the
// output beat waits, until the whole pipeline is full.
// When out_ch.ready is low the last stage holds its beat unchanged.
// Reset (rst_n low, synchronous) empties the pipeline and loads the plane
// registers with centre 0, normal (0, 1.0, 0), both modes off, count 0.
module ray_plane_hit_checker #(
  parameter int SQUARE_SIZE = rph_pkg::SQUARE_SIZE_DEF,
  parameter int FRAC_BITS   = rph_pkg::FRAC_BITS_DEF
) (
  input logic    clk,
  input logic    rst_n,
  rph_ray_if.sink   in_ch,
  rph_res_if.source out_ch,
  rph_cfg_if.sink   cfg_ch
);
  import rph_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int TW     = T_W;
  localparam int DEN_W  = 66 - F;
  localparam int NUM_W  = 67 - F;
  localparam int RW     = DEN_W + TW;
  localparam int HW     = 65 - F;
  localparam int HIW    = HW - F;
  localparam int NMS    = (HIW + 7) / 8;
  localparam int PADW   = NMS * 8;
  localparam int CW     = ((HW > 21 + F) ? HW : 21 + F) + 2;
  localparam int MODV   = 2 * SQUARE_SIZE;
  localparam int RMW    = $clog2(MODV) + 1;

  localparam int ST_DIV0 = 5;
  localparam int ST_Q    = ST_DIV0 + TW;
  localparam int ST_MUL  = ST_Q + 1;
  localparam int ST_HIT  = ST_Q + 2;
  localparam int ST_BND  = ST_Q + 3;
  localparam int ST_MOD0 = ST_Q + 4;
  localparam int ST_OUT  = ST_MOD0 + NMS;
  localparam int NST     = ST_OUT + 1;

  function automatic int pow2_mod(input int w, input int m);
    int r;
    r = 1;
    for (int i = 0; i < w; i++) begin
      r = r * 2;
      if (r >= m) r = r - m;
    end
    return r;
  endfunction

  localparam int PMOD = pow2_mod(PADW, MODV);

  function automatic logic [RMW-1:0] mod_step8(input logic [RMW-1:0] r,
                                               input logic [7:0] b);
    logic [RMW:0] acc;
    acc = {1'b0, r};
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[RMW-1:0], b[i]};
      if (acc >= (RMW+1)'(MODV)) acc = acc - (RMW+1)'(MODV);
    end
    return acc[RMW-1:0];
  endfunction

  function automatic logic cell_parity(input logic [RMW-1:0] r, input logic neg);
    logic signed [RMW+1:0] m;
    m = $signed({2'b00, r}) - (neg ? (RMW+2)'(PMOD) : '0);
    if (m < 0) m = m + (RMW+2)'(MODV);
    return m >= (RMW+2)'(SQUARE_SIZE);
  endfunction

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sz;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dz;
    logic               miss;
  } pass_t;

  typedef struct packed {
    logic [PADW-1:0] hx;
    logic [PADW-1:0] hz;
    logic [TW-1:0]   t;
    logic            miss;
  } cell_t;

  // configuration registers
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r, nx_r, ny_r, nz_r;
  logic [1:0]                mode_r;
  logic [7:0]                sq_cnt_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
      nx_r     <= '0;
      ny_r     <= COORD_W'(65536);
      nz_r     <= '0;
      mode_r   <= '0;
      sq_cnt_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CENTRE_X:  cx_r     <= cfg_ch.data;
        REG_CENTRE_Y:  cy_r     <= cfg_ch.data;
        REG_CENTRE_Z:  cz_r     <= cfg_ch.data;
        REG_NORMAL_X:  nx_r     <= cfg_ch.data;
        REG_NORMAL_Y:  ny_r     <= cfg_ch.data;
        REG_NORMAL_Z:  nz_r     <= cfg_ch.data;
        REG_MODE_BITS: mode_r   <= cfg_ch.data[1:0];
        REG_SQ_COUNT:  sq_cnt_r <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // valid chain: a stage advances when empty or when the next one advances
  logic [NST-1:0] v_r, en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (en & {v_r[NST-2:0], in_ch.valid}) | (~en & v_r);
    end
  end

  assign in_ch.ready = en[0];

  // stage 0: capture ray, centre minus start
  logic signed [COORD_W-1:0] s0_dx_r, s0_dy_r, s0_dz_r;
  logic [COORD_W-1:0]        s0_sx_r, s0_sz_r;
  logic signed [COORD_W:0]   s0_fx_r, s0_fy_r, s0_fz_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_sx_r <= in_ch.start_x;
      s0_sz_r <= in_ch.start_z;
      s0_dx_r <= in_ch.dir_x;
      s0_dy_r <= in_ch.dir_y;
      s0_dz_r <= in_ch.dir_z;
      s0_fx_r <= $signed({cx_r[COORD_W-1], cx_r})
               - $signed({in_ch.start_x[COORD_W-1], in_ch.start_x});
      s0_fy_r <= $signed({cy_r[COORD_W-1], cy_r})
               - $signed({in_ch.start_y[COORD_W-1], in_ch.start_y});
      s0_fz_r <= $signed({cz_r[COORD_W-1], cz_r})
               - $signed({in_ch.start_z[COORD_W-1], in_ch.start_z});
    end
  end

  // stage 1: products, floored to Q.F
  logic signed [63:0] pd_x, pd_y, pd_z;
  logic signed [64:0] pn_x, pn_y, pn_z;
  logic signed [63-F:0] s1_dtx_r, s1_dty_r, s1_dtz_r;
  logic signed [64-F:0] s1_ntx_r, s1_nty_r, s1_ntz_r;
  pass_t s1_p_r;

  assign pd_x = nx_r * s0_dx_r;
  assign pd_y = ny_r * s0_dy_r;
  assign pd_z = nz_r * s0_dz_r;
  assign pn_x = nx_r * s0_fx_r;
  assign pn_y = ny_r * s0_fy_r;
  assign pn_z = nz_r * s0_fz_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_dtx_r <= pd_x[63:F];
      s1_dty_r <= pd_y[63:F];
      s1_dtz_r <= pd_z[63:F];
      s1_ntx_r <= pn_x[64:F];
      s1_nty_r <= pn_y[64:F];
      s1_ntz_r <= pn_z[64:F];
      s1_p_r   <= '{sx: s0_sx_r, sz: s0_sz_r, dx: s0_dx_r, dz: s0_dz_r, miss: 1'b0};
    end
  end

  // stage 2: den and num sums
  logic signed [DEN_W-1:0] s2_den_r;
  logic signed [NUM_W-1:0] s2_num_r;
  pass_t s2_p_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_den_r <= DEN_W'(s1_dtx_r) + DEN_W'(s1_dty_r) + DEN_W'(s1_dtz_r);
      s2_num_r <= NUM_W'(s1_ntx_r) + NUM_W'(s1_nty_r) + NUM_W'(s1_ntz_r);
      s2_p_r   <= s1_p_r;
    end
  end

  // stage 3: magnitudes, drop parallel and backward rays
  logic [NUM_W-1:0] s3_un_r;
  logic [DEN_W-1:0] s3_ud_r;
  pass_t s3_p_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_un_r <= s2_num_r[NUM_W-1] ? NUM_W'(-s2_num_r) : NUM_W'(s2_num_r);
      s3_ud_r <= s2_den_r[DEN_W-1] ? DEN_W'(-s2_den_r) : DEN_W'(s2_den_r);
      s3_p_r  <= '{sx: s2_p_r.sx, sz: s2_p_r.sz, dx: s2_p_r.dx, dz: s2_p_r.dz,
                   miss: (s2_den_r == '0) || (s2_num_r == '0)
                      || (s2_num_r[NUM_W-1] != s2_den_r[DEN_W-1])};
    end
  end

  // stage 4: saturation test and dividend
  logic [RW-1:0] s4_rem_r;
  logic [DEN_W-1:0] s4_ud_r;
  logic s4_sat_r;
  pass_t s4_p_r;
  logic [RW-1:0] dvd_w;

  assign dvd_w = RW'(s3_un_r) << F;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_rem_r <= dvd_w;
      s4_ud_r  <= s3_ud_r;
      s4_sat_r <= dvd_w >= (RW'(s3_ud_r) << TW);
      s4_p_r   <= s3_p_r;
    end
  end

  // divider: one quotient bit per stage, most significant first
  logic [RW-1:0]    dv_rem_r [TW];
  logic [TW-1:0]    dv_q_r   [TW];
  logic [DEN_W-1:0] dv_ud_r  [TW];
  logic             dv_sat_r [TW];
  pass_t            dv_p_r   [TW];

  for (genvar i = 0; i < TW; i++) begin : g_div
    localparam int K = TW - 1 - i;
    logic [RW-1:0]    rem_in;
    logic [TW-1:0]    q_in;
    logic [DEN_W-1:0] ud_in;
    logic             sat_in;
    pass_t            p_in;
    logic [RW-1:0]    ud_sh;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = s4_rem_r;
      assign q_in   = '0;
      assign ud_in  = s4_ud_r;
      assign sat_in = s4_sat_r;
      assign p_in   = s4_p_r;
    end else begin : g_next
      assign rem_in = dv_rem_r[i-1];
      assign q_in   = dv_q_r[i-1];
      assign ud_in  = dv_ud_r[i-1];
      assign sat_in = dv_sat_r[i-1];
      assign p_in   = dv_p_r[i-1];
    end

    assign ud_sh = RW'(ud_in) << K;
    assign take  = !sat_in && (rem_in >= ud_sh);

    always_ff @(posedge clk) begin
      if (en[ST_DIV0+i]) begin
        dv_rem_r[i] <= take ? rem_in - ud_sh : rem_in;
        dv_q_r[i]   <= q_in | (take ? (TW'(1) << K) : '0);
        dv_ud_r[i]  <= ud_in;
        dv_sat_r[i] <= sat_in;
        dv_p_r[i]   <= p_in;
      end
    end
  end

  // t with saturation, drop t below one LSB
  logic [TW-1:0] q_t_w;
  logic [TW-1:0] sq_t_r;
  pass_t sq_p_r;

  assign q_t_w = dv_sat_r[TW-1] ? T_MAX : dv_q_r[TW-1];

  always_ff @(posedge clk) begin
    if (en[ST_Q]) begin
      sq_t_r <= q_t_w;
      sq_p_r <= '{sx: dv_p_r[TW-1].sx, sz: dv_p_r[TW-1].sz,
                  dx: dv_p_r[TW-1].dx, dz: dv_p_r[TW-1].dz,
                  miss: dv_p_r[TW-1].miss || (q_t_w == '0)};
    end
  end

  // dir times t
  logic signed [63:0] sm_px_r, sm_pz_r;
  logic [COORD_W-1:0] sm_sx_r, sm_sz_r;
  logic [TW-1:0]      sm_t_r;
  logic               sm_miss_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      sm_px_r   <= $signed(sq_p_r.dx) * $signed({1'b0, sq_t_r});
      sm_pz_r   <= $signed(sq_p_r.dz) * $signed({1'b0, sq_t_r});
      sm_sx_r   <= sq_p_r.sx;
      sm_sz_r   <= sq_p_r.sz;
      sm_t_r    <= sq_t_r;
      sm_miss_r <= sq_p_r.miss;
    end
  end

  // hit point
  logic signed [63:0] px_sh, pz_sh;
  logic signed [HW-1:0] sh_hx_r, sh_hz_r;
  logic [TW-1:0] sh_t_r;
  logic          sh_miss_r;

  assign px_sh = sm_px_r >>> F;
  assign pz_sh = sm_pz_r >>> F;

  always_ff @(posedge clk) begin
    if (en[ST_HIT]) begin
      sh_hx_r   <= HW'($signed(sm_sx_r)) + HW'(px_sh);
      sh_hz_r   <= HW'($signed(sm_sz_r)) + HW'(pz_sh);
      sh_t_r    <= sm_t_r;
      sh_miss_r <= sm_miss_r;
    end
  end

  // extent check, cell coordinates
  logic signed [CW-1:0] bnd_w, hxw, hzw, cxw, czw;
  logic                 outside;
  logic signed [HIW-1:0] hix, hiz;
  cell_t bd_r;

  assign bnd_w = (CW'(SQUARE_SIZE) * CW'(sq_cnt_r)) <<< F;
  assign hxw   = CW'(sh_hx_r);
  assign hzw   = CW'(sh_hz_r);
  assign cxw   = CW'(cx_r);
  assign czw   = CW'(cz_r);
  assign outside = mode_r[MODE_LIMIT]
                && ((hxw > cxw + bnd_w) || (hxw < cxw - bnd_w)
                 || (hzw > czw + bnd_w) || (hzw < czw - bnd_w));
  assign hix = sh_hx_r[HW-1:F];
  assign hiz = sh_hz_r[HW-1:F];

  always_ff @(posedge clk) begin
    if (en[ST_BND]) begin
      bd_r <= '{hx: PADW'(hix), hz: PADW'(hiz), t: sh_t_r,
                miss: sh_miss_r || outside};
    end
  end

  // cell coordinate modulo twice the square size, 8 bits per stage
  logic [RMW-1:0] md_rx_r [NMS];
  logic [RMW-1:0] md_rz_r [NMS];
  cell_t          md_c_r  [NMS];

  for (genvar j = 0; j < NMS; j++) begin : g_mod
    logic [RMW-1:0] rx_in, rz_in;
    cell_t          c_in;

    if (j == 0) begin : g_first
      assign rx_in = '0;
      assign rz_in = '0;
      assign c_in  = bd_r;
    end else begin : g_next
      assign rx_in = md_rx_r[j-1];
      assign rz_in = md_rz_r[j-1];
      assign c_in  = md_c_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (en[ST_MOD0+j]) begin
        md_rx_r[j] <= mod_step8(rx_in, c_in.hx[PADW-1-8*j -: 8]);
        md_rz_r[j] <= mod_step8(rz_in, c_in.hz[PADW-1-8*j -: 8]);
        md_c_r[j]  <= c_in;
      end
    end
  end

  // output register
  logic               out_hit_r;
  logic [TW-1:0]      out_t_r;
  logic [COLOR_W-1:0] out_col_r;
  logic               par_x, par_z;
  cell_t              last_c;

  assign last_c = md_c_r[NMS-1];
  assign par_x  = cell_parity(md_rx_r[NMS-1], last_c.hx[PADW-1]);
  assign par_z  = cell_parity(md_rz_r[NMS-1], last_c.hz[PADW-1]);

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_hit_r <= !last_c.miss;
      out_t_r   <= last_c.miss ? '0 : last_c.t;
      if (last_c.miss || !mode_r[MODE_CHESS]) begin
        out_col_r <= COLOR_BASE;
      end else begin
        out_col_r <= (par_x == par_z) ? COLOR_WHITE : COLOR_BLACK;
      end
    end
  end

  assign out_ch.valid      = v_r[NST-1];
  assign out_ch.hit        = out_hit_r;
  assign out_ch.distance_t = out_t_r;
  assign out_ch.color_code = out_col_r;

`include "ray_plane_hit_checker_assert.svh"

  `RPH_ASSERT_NOW(a_hit_has_t, out_ch.valid && out_ch.hit, out_ch.distance_t != '0)
  `RPH_ASSERT_NOW(a_miss_clean, out_ch.valid && !out_ch.hit, out_ch.distance_t == '0 && out_ch.color_code == COLOR_BASE)
  `RPH_ASSERT_NOW(a_chess_off, out_ch.valid && !mode_r[MODE_CHESS], out_ch.color_code == COLOR_BASE)
  `RPH_ASSERT_NEXT(a_div_hold, v_r[ST_Q] && !en[ST_Q], v_r[ST_Q] && $stable(sq_t_r))

endmodule

@@ tb/rph_hit_scoreboard.sv @@
// Checker: watches the ray, result and register channels, predicts each hit and compares.
`timescale 1ns / 100ps
module rph_hit_scoreboard #(
  parameter int SQUARE_SIZE = rph_pkg::SQUARE_SIZE_DEF,
  parameter int FRAC_BITS   = rph_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rph_ray_if   ray,
  rph_res_if   res,
  rph_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   hit_count
);
  import rph_pkg::*;

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] distance_t;
    logic [1:0]     color_code;
  } hit_rec_t;

  longint plane_cx, plane_cy, plane_cz, plane_nx, plane_ny, plane_nz;
  logic [1:0] plane_mode;
  logic [7:0] plane_sq;
  hit_rec_t   hit_q[$];

  function automatic longint fx_mul(input longint a, input longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    return longint'(p >>> FRAC_BITS);
  endfunction

  function automatic longint cell_of(input longint h);
    longint c, q;
    c = longint'(SQUARE_SIZE) <<< FRAC_BITS;
    q = h / c;
    if ((h % c) != 0 && h < 0) q = q - 1;
    return q;
  endfunction

  function automatic hit_rec_t predict_hit(input logic signed [31:0] sx, sy, sz, dx, dy, dz);
    longint den, num, hx, hz, bound, cell_x, cell_z;
    longint unsigned un, ud, q, r;
    int i;
    hit_rec_t o;
    o = '0;
    den = fx_mul(plane_nx, dx) + fx_mul(plane_ny, dy) + fx_mul(plane_nz, dz);
    if (den == 0) return o;
    num = fx_mul(plane_nx, plane_cx - longint'(sx)) + fx_mul(plane_ny, plane_cy - longint'(sy))
        + fx_mul(plane_nz, plane_cz - longint'(sz));
    if (num == 0 || ((num < 0) != (den < 0))) return o;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = un / ud;
    r = un % ud;
    for (i = 0; i < FRAC_BITS && q <= 64'h7FFFFFFF; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q + 1;
      end
    end
    if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
    if (q == 0) return o;
    hx = longint'(sx) + fx_mul(dx, longint'(q));
    hz = longint'(sz) + fx_mul(dz, longint'(q));
    if (plane_mode[MODE_LIMIT]) begin
      bound = (longint'(SQUARE_SIZE) * longint'(plane_sq)) <<< FRAC_BITS;
      if (hx > plane_cx + bound || hx < plane_cx - bound ||
          hz > plane_cz + bound || hz < plane_cz - bound) return o;
    end
    o.hit = 1'b1;
    o.distance_t = q[T_W-1:0];
    if (plane_mode[MODE_CHESS]) begin
      cell_x = cell_of(hx);
      cell_z = cell_of(hz);
      o.color_code = (cell_x[0] == cell_z[0]) ? COLOR_WHITE : COLOR_BLACK;
    end
    return o;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    hit_count = 0;
  end

  always @(posedge clk) begin
    hit_rec_t want;
    if (!rst_n) begin
      plane_cx <= 0; plane_cy <= 0; plane_cz <= 0;
      plane_nx <= 0; plane_ny <= 65536; plane_nz <= 0;
      plane_mode <= '0;
      plane_sq <= '0;
      hit_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (hit_q.size() == 0) begin
          $error("result beat with no ray outstanding");
          fail_count++;
        end else begin
          want = hit_q.pop_front();
          if (res.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, res.hit);
            fail_count++;
          end
          if (res.distance_t !== want.distance_t) begin
            $error("distance_t: expected %h, got %h", want.distance_t, res.distance_t);
            fail_count++;
          end
          if (res.color_code !== want.color_code) begin
            $error("color_code: expected %0d, got %0d", want.color_code, res.color_code);
            fail_count++;
          end
          if (want.hit) hit_count++;
        end
      end
      if (ray.valid && ray.ready)
        hit_q.push_back(predict_hit(ray.start_x, ray.start_y, ray.start_z,
                                    ray.dir_x, ray.dir_y, ray.dir_z));
      if (cfg.valid && cfg.ready) begin
        case (rph_reg_t'(cfg.index))
          REG_CENTRE_X:  plane_cx <= longint'($signed(cfg.data));
          REG_CENTRE_Y:  plane_cy <= longint'($signed(cfg.data));
          REG_CENTRE_Z:  plane_cz <= longint'($signed(cfg.data));
          REG_NORMAL_X:  plane_nx <= longint'($signed(cfg.data));
          REG_NORMAL_Y:  plane_ny <= longint'($signed(cfg.data));
          REG_NORMAL_Z:  plane_nz <= longint'($signed(cfg.data));
          REG_MODE_BITS: plane_mode <= cfg.data[1:0];
          REG_SQ_COUNT:  plane_sq <= cfg.data[7:0];
          default: ;
        endcase
      end
    end
    pending = hit_q.size();
  end

endmodule

@@ tb/tb_ray_plane_hit_checker.sv @@
// Testbench top: drives rays and plane settings into the hit checker and reports the verdict.
`timescale 1ns / 100ps
module tb_ray_plane_hit_checker;
  import rph_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count, pending, hit_count;
  int   ray_total, stall_left;
  bit   idle_on;

  rph_ray_if ray_ch ();
  rph_res_if res_ch ();
  rph_cfg_if cfg_ch ();

  ray_plane_hit_checker i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(ray_ch.sink), .out_ch(res_ch.source), .cfg_ch(cfg_ch.sink)
  );

  rph_hit_scoreboard i_scoreboard (
    .clk(clk), .rst_n(rst_n), .ray(ray_ch), .res(res_ch), .cfg(cfg_ch),
    .fail_count(fail_count), .pending(pending), .hit_count(hit_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    res_ch.ready = 1'b1;
    stall_left = 0;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic send_ray(input logic [31:0] sx, sy, sz, dx, dy, dz);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      ray_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.start_x <= sx; ray_ch.start_y <= sy; ray_ch.start_z <= sz;
    ray_ch.dir_x <= dx;   ray_ch.dir_y <= dy;   ray_ch.dir_z <= dz;
    do @(posedge clk); while (!ray_ch.ready);
    ray_total++;
  endtask

  task automatic write_reg(input rph_reg_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_plane(input logic [31:0] cx, cy, cz, nx, ny, nz,
                             input logic [1:0] mode, input logic [7:0] sq);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_CENTRE_Z, cz);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_MODE_BITS, {30'd0, mode});
    write_reg(REG_SQ_COUNT, {24'd0, sq});
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending != 0);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    ray_total = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    ray_ch.valid = 1'b0;
    ray_ch.start_x = '0; ray_ch.start_y = '0; ray_ch.start_z = '0;
    ray_ch.dir_x = '0;   ray_ch.dir_y = '0;   ray_ch.dir_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset plane: y = 0, normal +y, no modes
    send_ray(0, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 0);
    send_ray(32'h0012_3456, 32'h0001_0000, 32'hFFF0_0000, 0, 0, 0);
    send_ray(32'h0005_0000, 0, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 0);
    send_ray(0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
    send_ray(0, 32'h0000_0001, 0, 0, 32'h8000_0001, 0);
    send_ray(0, 32'h7FFF_FFFF, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(0, 32'hFFFF_0000, 0, 0, 32'h0000_0001, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_plane(near(1 << 22), near(1 << 20), near(1 << 22), 0, 32'h0001_0000, 0,
                       2'd3, 8'd255);
        2: write_plane(0, 0, 0, 0, 32'hFFFF_0000, 0, 2'd3, 8'd0);
        3: write_plane(near(1 << 20), near(1 << 20), near(1 << 20),
                       near(1 << 17), near(1 << 17), near(1 << 17), 2'd1, 8'd3);
        4: write_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 2'd2, 8'd255);
        5: write_plane(pick_word(), near(1 << 20), pick_word(), near(1 << 16),
                       32'h0001_0000 + near(1 << 15), near(1 << 16),
                       2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        default: ;
      endcase
      idle_on = (ph < 5);
      for (int n = 0; n < 265; n++) begin
        if ($urandom_range(0, 9) < 7)
          send_ray(near(1 << 24), near(1 << 24), near(1 << 24),
                   near(1 << 17), near(1 << 17), near(1 << 17));
        else if (ph == 2 && $urandom_range(0, 1) == 0)
          send_ray(near(4) << 16, near(1 << 20), 0, 0, near(1 << 17), 0);
        else
          send_ray(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
      end
      @(negedge clk);
      ray_ch.valid <= 1'b0;
      drain();
    end

    $display("Sent %0d rays across 6 plane settings; %0d of them hit.", ray_total, hit_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
